/* sv/phfe_pkg.sv */
`default_nettype none
package phfe_pkg;

  localparam int unsigned NumPh = 38;

  typedef logic [5:0] phase_t;
  typedef logic [5:0] code_t;

  localparam phase_t PH_DMAC    = 6'd0;
  localparam phase_t PH_TYPE    = 6'd2;
  localparam phase_t PH_TCI     = 6'd3;
  localparam phase_t PH_HRD     = 6'd4;
  localparam phase_t PH_TPA     = 6'd12;
  localparam phase_t PH_VIHL    = 6'd13;
  localparam phase_t PH_LEN     = 6'd15;
  localparam phase_t PH_OFF     = 6'd17;
  localparam phase_t PH_PROTO   = 6'd19;
  localparam phase_t PH_DST     = 6'd22;
  localparam phase_t PH_IPOPT   = 6'd23;
  localparam phase_t PH_TSP     = 6'd24;
  localparam phase_t PH_OFFFL   = 6'd28;
  localparam phase_t PH_URP     = 6'd31;
  localparam phase_t PH_TOPT    = 6'd32;
  localparam phase_t PH_USP     = 6'd33;
  localparam phase_t PH_USUM    = 6'd36;
  localparam phase_t PH_PAYLOAD = 6'd37;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_RARP = 16'h8035;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [5:0]  FIXED_HDR  = 6'd20;

  localparam code_t C_TPID    = 6'd2;
  localparam code_t C_PCP     = 6'd3;
  localparam code_t C_DEI     = 6'd4;
  localparam code_t C_VID     = 6'd5;
  localparam code_t C_ETYPE   = 6'd6;
  localparam code_t C_TPA     = 6'd15;
  localparam code_t C_IPVER   = 6'd16;
  localparam code_t C_IHL     = 6'd17;
  localparam code_t C_RSV     = 6'd21;
  localparam code_t C_DF      = 6'd22;
  localparam code_t C_MF      = 6'd23;
  localparam code_t C_FRAG    = 6'd24;
  localparam code_t C_IPDST   = 6'd29;
  localparam code_t C_THL     = 6'd34;
  localparam code_t C_TFLAGS  = 6'd35;
  localparam code_t C_L4SUM   = 6'd37;
  localparam code_t C_URG     = 6'd38;
  localparam code_t C_PAYLOAD = 6'd41;
  localparam code_t C_END     = 6'd42;

  // one decoded byte: up to four results
  typedef enum logic [3:0] {
    K_NONE, K_SIMPLE, K_TPID, K_TCI, K_VIHL, K_OFF, K_OFFFL, K_PAYLOAD, K_END
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    code_t       code;
    logic        fend;
    logic [47:0] value;
    logic [15:0] fidx;
  } job_t;

  typedef struct packed {
    code_t       code;
    logic [47:0] value;
    logic        fend;
    logic [15:0] fidx;
  } res_t;

  function automatic logic [2:0] ph_len(input phase_t p);
    case (p)
      6'd0, 6'd1, 6'd9, 6'd11:                         ph_len = 3'd6;
      6'd10, 6'd12, 6'd21, 6'd22, 6'd26, 6'd27:       ph_len = 3'd4;
      6'd6, 6'd7, 6'd13, 6'd14, 6'd18, 6'd19:         ph_len = 3'd1;
      6'd23, 6'd32, 6'd37:                             ph_len = 3'd0;
      default:                                         ph_len = 3'd2;
    endcase
  endfunction

  function automatic code_t ph_code(input phase_t p);
    case (p)
      6'd0: ph_code = 6'd0;   6'd1: ph_code = 6'd1;   6'd2: ph_code = 6'd6;
      6'd3: ph_code = 6'd5;   6'd13: ph_code = 6'd16; 6'd14: ph_code = 6'd18;
      6'd15: ph_code = 6'd19; 6'd16: ph_code = 6'd20; 6'd17: ph_code = 6'd24;
      6'd18: ph_code = 6'd25; 6'd19: ph_code = 6'd26; 6'd20: ph_code = 6'd27;
      6'd21: ph_code = 6'd28; 6'd22: ph_code = 6'd29; 6'd23: ph_code = 6'd42;
      6'd24: ph_code = 6'd30; 6'd25: ph_code = 6'd31; 6'd26: ph_code = 6'd32;
      6'd27: ph_code = 6'd33; 6'd28: ph_code = 6'd34; 6'd29: ph_code = 6'd36;
      6'd30: ph_code = 6'd37; 6'd31: ph_code = 6'd38; 6'd32: ph_code = 6'd42;
      6'd33: ph_code = 6'd30; 6'd34: ph_code = 6'd31; 6'd35: ph_code = 6'd39;
      6'd36: ph_code = 6'd37; 6'd37: ph_code = 6'd41;
      default: ph_code = 6'(p + 6'd3);
    endcase
  endfunction

endpackage
`default_nettype wire

/* sv/packet_header_field_extractor.sv */
`default_nettype none
// Byte-serial Ethernet/VLAN/ARP/IPv4/TCP/UDP header parser. One frame byte is
// accepted per cycle while in_tready is high; the front stage tracks the
// header position and hands completed fields through a four-entry queue to
// the back stage, which emits one result per cycle unless out_tready stalls.
// Bytes completing a tag TCI (3 results), IPv4 flags/offset (4), version/IHL
// or TCP offset/flags (2) emit each in turn, so input slows behind those.
module packet_header_field_extractor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // field_value, frame_index
  output logic [5:0]       out_tuser,  // field_code
  output logic             out_tlast   // frame_end
);
  import phfe_pkg::*;

  logic fj_v, fj_r, bj_v, bj_r, ov_r;
  job_t fj, bj;
  res_t br, o_r;
  logic ov_n;

  phfe_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_byte(in_tdata),
    .job_valid(fj_v), .job_ready(fj_r), .job(fj)
  );
  phfe_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fj_v), .wr_ready(fj_r), .wr_data(fj),
    .rd_valid(bj_v), .rd_ready(bj_r), .rd_data(bj)
  );
  phfe_back u_back (
    .clk, .rst_n, .job_valid(bj_v), .job_ready(bj_r), .job(bj),
    .out_valid(ov_n), .out_ready(!ov_r || out_tready), .res(br)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (!ov_r || out_tready) ov_r <= ov_n;
  end
  always_ff @(posedge clk) begin
    if (!ov_r || out_tready) o_r <= br;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {o_r.fidx, o_r.value};
  assign out_tuser  = o_r.code;
  assign out_tlast  = o_r.fend;
endmodule
`default_nettype wire

/* sv/phfe_front.sv */
`default_nettype none
module phfe_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           cfg_idx,
  input  wire logic [15:0]    cfg_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  output logic                job_valid,
  input  wire logic           job_ready,
  output phfe_pkg::job_t      job
);
  import phfe_pkg::*;

  logic [15:0] outer_r, inner_r;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  bif_r, bif_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [5:0]  ihb_r, ihb_nxt;
  logic [5:0]  l4b_r, l4b_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] fcnt_r;
  logic        jv_r;
  job_t        job_r;
  job_t        jn;
  logic        ending;
  logic        acc;
  logic [47:0] v;
  logic [15:0] t;
  phase_t      ph;
  logic [17:0] pay;

  assign in_ready  = !jv_r || job_ready;
  assign acc       = in_valid && in_ready;
  assign job_valid = jv_r;
  assign job       = job_r;

  always_comb begin
    phase_nxt = phase_r; bif_nxt = bif_r; rem_nxt = rem_r; shift_nxt = shift_r;
    tlen_nxt = tlen_r; ihb_nxt = ihb_r; l4b_nxt = l4b_r; proto_nxt = proto_r;
    ending = 1'b0;
    jn = '0;
    jn.kind = K_NONE;
    jn.fidx = fcnt_r;
    v = {shift_r[39:0], in_byte};
    t = v[15:0];
    ph = (phase_r >= 6'(NumPh)) ? PH_DMAC : phase_r;
    pay = 18'd0;
    if (ph == PH_IPOPT || ph == PH_TOPT) begin
      if (rem_r <= 16'd1) begin
        rem_nxt = '0;
        if (ph == PH_IPOPT && proto_r == PROTO_TCP) phase_nxt = PH_TSP;
        else if (ph == PH_IPOPT && proto_r == PROTO_UDP) phase_nxt = PH_USP;
        else begin
          if (ph == PH_IPOPT) l4b_nxt = '0;
          pay = {2'b0, tlen_r} - 18'(ihb_r) - ((ph == PH_IPOPT) ? 18'd0 : 18'(l4b_r));
          if (!pay[17] && pay != 0) begin
            rem_nxt = pay[15:0]; phase_nxt = PH_PAYLOAD;
          end else ending = 1'b1;
        end
      end else rem_nxt = rem_r - 16'd1;
    end else if (ph == PH_PAYLOAD) begin
      jn.kind = K_PAYLOAD; jn.code = C_PAYLOAD; jn.value = {40'd0, in_byte};
      if (rem_r <= 16'd1) begin
        rem_nxt = '0; ending = 1'b1;
      end else rem_nxt = rem_r - 16'd1;
    end else if (bif_r + 3'd1 < ph_len(ph)) begin
      bif_nxt = bif_r + 3'd1; shift_nxt = v; phase_nxt = ph;
    end else begin
      bif_nxt = '0; shift_nxt = '0;
      jn.value = v; jn.kind = K_SIMPLE; jn.code = ph_code(ph);
      phase_nxt = ph + 6'd1;
      case (ph)
        PH_TYPE: begin
          jn.value = {32'd0, t};
          if (t == outer_r || t == inner_r) begin
            jn.kind = K_TPID; phase_nxt = PH_TCI;
          end else if (t == ETYPE_ARP || t == ETYPE_RARP) phase_nxt = PH_HRD;
          else if (t == ETYPE_IPV4) phase_nxt = PH_VIHL;
          else ending = 1'b1;
        end
        PH_TCI: begin jn.kind = K_TCI; phase_nxt = PH_TYPE; end
        PH_TPA: begin jn.code = C_TPA; ending = 1'b1; end
        PH_VIHL: begin jn.kind = K_VIHL; ihb_nxt = {v[3:0], 2'b00}; end
        PH_LEN: tlen_nxt = t;
        PH_OFF: jn.kind = K_OFF;
        PH_PROTO: proto_nxt = v[7:0];
        PH_DST, PH_URP, PH_USUM: begin
          if (ph == PH_DST && ihb_r > FIXED_HDR) begin
            rem_nxt = 16'(ihb_r - FIXED_HDR); phase_nxt = PH_IPOPT;
          end else if (ph == PH_DST && proto_r == PROTO_TCP) phase_nxt = PH_TSP;
          else if (ph == PH_DST && proto_r == PROTO_UDP) phase_nxt = PH_USP;
          else if (ph == PH_URP && l4b_r > FIXED_HDR) begin
            rem_nxt = 16'(l4b_r - FIXED_HDR); phase_nxt = PH_TOPT;
          end else begin
            if (ph == PH_DST) l4b_nxt = '0;
            if (ph == PH_USUM) l4b_nxt = 6'd8;
            pay = {2'b0, tlen_r} - 18'(ihb_r) -
                  ((ph == PH_DST) ? 18'd0 : (ph == PH_USUM) ? 18'd8 : 18'(l4b_r));
            if (!pay[17] && pay != 0) begin
              rem_nxt = pay[15:0]; phase_nxt = PH_PAYLOAD;
            end else ending = 1'b1;
          end
        end
        PH_OFFFL: begin jn.kind = K_OFFFL; l4b_nxt = {v[15:12], 2'b00}; end
        default: ;
      endcase
    end
    if (ending) begin
      jn.fend = 1'b1;
      if (jn.kind == K_NONE) begin
        jn.kind = K_END; jn.code = C_END; jn.value = '0;
      end
      phase_nxt = PH_DMAC; bif_nxt = '0; shift_nxt = '0; rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r <= 16'h88A8; inner_r <= 16'h8100;
      phase_r <= PH_DMAC; bif_r <= '0; rem_r <= '0; shift_r <= '0;
      tlen_r <= '0; ihb_r <= '0; l4b_r <= '0; proto_r <= '0; fcnt_r <= '0;
      jv_r <= 1'b0;
    end else begin
      if (cfg_we && !cfg_idx) outer_r <= cfg_data;
      if (cfg_we && cfg_idx) inner_r <= cfg_data;
      if (acc) begin
        phase_r <= phase_nxt; bif_r <= bif_nxt; rem_r <= rem_nxt;
        shift_r <= shift_nxt; tlen_r <= tlen_nxt; ihb_r <= ihb_nxt;
        l4b_r <= l4b_nxt; proto_r <= proto_nxt;
        if (ending) fcnt_r <= fcnt_r + 16'd1;
        jv_r <= (jn.kind != K_NONE);
      end else if (job_ready) jv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) job_r <= jn;
  end
endmodule
`default_nettype wire

/* sv/phfe_fifo.sv */
`default_nettype none
module phfe_fifo (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  phfe_pkg::job_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output phfe_pkg::job_t rd_data
);
  import phfe_pkg::*;

  job_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

/* sv/phfe_back.sv */
`default_nettype none
module phfe_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  output logic           job_ready,
  input  phfe_pkg::job_t job,
  output logic           out_valid,
  input  wire logic      out_ready,
  output phfe_pkg::res_t res
);
  import phfe_pkg::*;

  logic [1:0] sub_r;
  logic [1:0] last;
  logic       adv;
  res_t       r;
  logic [47:0] v;

  assign v = job.value;

  always_comb begin
    r.fidx = job.fidx;
    r.code = job.code;
    r.value = v;
    last = 2'd0;
    case (job.kind)
      K_TPID: r.code = C_TPID;
      K_TCI: begin
        last = 2'd2;
        case (sub_r)
          2'd0: begin r.code = C_PCP; r.value = {45'd0, v[15:13]}; end
          2'd1: begin r.code = C_DEI; r.value = {47'd0, v[12]}; end
          default: begin r.code = C_VID; r.value = {36'd0, v[11:0]}; end
        endcase
      end
      K_VIHL: begin
        last = 2'd1;
        if (sub_r == 2'd0) begin r.code = C_IPVER; r.value = {44'd0, v[7:4]}; end
        else begin r.code = C_IHL; r.value = {42'd0, v[3:0], 2'b00}; end
      end
      K_OFF: begin
        last = 2'd3;
        case (sub_r)
          2'd0: begin r.code = C_RSV; r.value = {47'd0, v[15]}; end
          2'd1: begin r.code = C_DF; r.value = {47'd0, v[14]}; end
          2'd2: begin r.code = C_MF; r.value = {47'd0, v[13]}; end
          default: begin r.code = C_FRAG; r.value = {32'd0, v[12:0], 3'b000}; end
        endcase
      end
      K_OFFFL: begin
        last = 2'd1;
        if (sub_r == 2'd0) begin r.code = C_THL; r.value = {42'd0, v[15:12], 2'b00}; end
        else begin r.code = C_TFLAGS; r.value = {40'd0, v[7:0]}; end
      end
      default: ;
    endcase
    r.fend = job.fend && (sub_r == last);
  end

  assign out_valid = job_valid;
  assign res = r;
  assign adv = job_valid && out_ready;
  assign job_ready = adv && (sub_r == last);

  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= '0;
    else if (adv) sub_r <= (sub_r == last) ? 2'd0 : sub_r + 2'd1;
  end
endmodule
`default_nettype wire

/* sv/phfe_checker.sv */
`default_nettype none
module phfe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [5:0]  out_tuser,
  input wire logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("output dropped");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= 6'd42 && out_tuser != 6'd40)
    else $error("bad field code");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 6'd42 |-> out_tlast && out_tdata[47:0] == 48'd0)
    else $error("frame end marker wrong");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid |->
    out_tdata[63:48] == $past(out_tdata[63:48]))
    else $error("frame index changed inside frame");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_tready) && !$isunknown(out_tvalid))
    else $error("handshake unknown");
endmodule

bind packet_header_field_extractor phfe_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);
`default_nettype wire
